### rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion macros shared by the positional list engine.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset
`define PLE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Expression must never be true outside reset
`define PLE_ASSERT_NEVER(lbl, clk, rst, expr) \
   `PLE_ASSERT(lbl, clk, rst, !(expr))

`else

`define PLE_ASSERT(lbl, clk, rst, prop)
`define PLE_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

### rtl/ple_pkg.sv
// ============================================================================
// ple_pkg
// Types, constants and control structs of the positional list engine.
// ============================================================================
package ple_pkg;

   // Storage geometry
   localparam int DEPTH       = 64;
   localparam int VALUE_WIDTH = 32;

   // Fixed field widths of the channels
   localparam int OP_WIDTH   = 3;
   localparam int POS_WIDTH  = 7;
   localparam int DATA_WIDTH = 32;

   // Derived widths
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH  = $clog2(DEPTH + 1);
   localparam int CMP_WIDTH  = ((CNT_WIDTH > POS_WIDTH) ? CNT_WIDTH : POS_WIDTH) + 1;

   // Operation codes
   typedef enum logic [OP_WIDTH-1:0] {
      OP_INSERT = 3'd0,
      OP_APPEND = 3'd1,
      OP_REMOVE = 3'd2,
      OP_READ   = 3'd3,
      OP_FIND   = 3'd4,
      OP_SIZE   = 3'd5
   } op_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_RD,
      ST_INS_WR,
      ST_RM_DATA,
      ST_RM_RD,
      ST_RM_WR,
      ST_RD_DATA,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_DONE
   } state_type;

   // RAM address sources
   typedef enum logic [1:0] {
      ADDR_IDX,
      ADDR_IDX_M1,
      ADDR_POS_M1,
      ADDR_COUNT
   } addr_sel_type;

   // Walk index updates
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_LOAD_COUNT,
      IDX_LOAD_POS,
      IDX_CLEAR,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic         req_ready;
      logic         load_req;
      logic         rd_en;
      addr_sel_type rd_sel;
      logic         wr_en;
      addr_sel_type wr_sel;
      logic         wr_from_ram;
      idx_op_type   idx_op;
      logic         count_inc;
      logic         count_dec;
      logic         set_ok;
      logic         take_data;
      logic         take_found;
      logic         load_rsp;
   } ple_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic                 req_valid;
      op_type               op;
      logic                 pos_in_list;
      logic                 pos_insertable;
      logic                 full;
      logic                 idx_at_or_above_pos;
      logic                 idx_below_count;
      logic                 match;
      logic                 rsp_free;
      logic [CNT_WIDTH-1:0] count;
   } ple_status_type;

endpackage

### rtl/ple_channels.sv
// ============================================================================
// ple_channels
// Valid/ready channel interfaces for requests and responses.
// ============================================================================

// Request channel: operation, position and value
interface ple_req_if import ple_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [OP_WIDTH-1:0]          operation;
   logic [POS_WIDTH-1:0]         position;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, operation, position, value, input ready);
   modport sink   (input valid, operation, position, value, output ready);
endinterface

// Response channel: one result per request
interface ple_rsp_if import ple_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic signed [DATA_WIDTH-1:0] data;
   logic [POS_WIDTH-1:0]         found_position;
   logic [POS_WIDTH-1:0]         entry_total;
   logic                         is_empty;

   modport source (output valid, ok, data, found_position, entry_total, is_empty,
                   input ready);
   modport sink   (input valid, ok, data, found_position, entry_total, is_empty,
                   output ready);
endinterface

### rtl/positional_list_engine.sv
// ============================================================================
// positional_list_engine
// Ordered list of signed values with insert, append, remove, read, find and
// size requests, one response per request.
// ============================================================================
//
// Usage:
//   Requests arrive on req_ch (valid/ready) with operation, position and
//   value; each one gives exactly one response on rsp_ch (valid/ready) with
//   ok, data, found_position, entry_total and is_empty.
//   One request is worked on at a time. Insert moves the entries from the
//   position to the end back by one place, remove moves the entries behind
//   the removed one forward, and find compares entries from the first until
//   a match or the end. Every moved or compared entry takes a registered
//   read of the list store RAM and then its write or compare. The response
//   is loaded into its output register once the work ends and that register
//   is free.
//   Reset clears the entry count and the response valid; the list store is
//   not cleared, as only entries below the count are ever read.
//   A stalled response is held in its output register; the next request is
//   still accepted and worked, and its response waits until the first is
//   taken.
//
`include "assert_macros.svh"

module positional_list_engine import ple_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ple_req_if.sink   req_ch,
   ple_rsp_if.source rsp_ch
);

   ple_cmd_type    cmd;
   ple_status_type status;

   // Sequencer
   ple_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Storage and response path
   ple_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );

   // Checks
   `PLE_ASSERT_NEVER(a_count_bound, clock, reset, status.count > CNT_WIDTH'(DEPTH))
   `PLE_ASSERT(a_count_hold, clock, reset, (!cmd.count_inc && !cmd.count_dec) |=> $stable(status.count))
   `PLE_ASSERT_NEVER(a_no_write_when_idle, clock, reset, cmd.req_ready && cmd.wr_en)
   `PLE_ASSERT(a_one_in_flight, clock, reset, (req_ch.valid && req_ch.ready) |=> !req_ch.ready)

endmodule

### rtl/ple_ram.sv
// ============================================================================
// ple_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ple_ctrl.sv
// ============================================================================
// ple_ctrl
// Sequencer of the positional list engine: decodes a request and walks the
// list store one entry at a time for shifts and searches.
// ============================================================================
module ple_ctrl import ple_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  ple_status_type status,
   output ple_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.rd_sel      = ADDR_IDX;
      cmd.wr_sel      = ADDR_IDX;
      cmd.idx_op      = IDX_HOLD;

      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in = ST_DONE;
            case (status.op)
               OP_INSERT: begin
                  // start from the tail and move entries back
                  if (status.pos_insertable && !status.full) begin
                     cmd.idx_op = IDX_LOAD_COUNT;
                     state_in   = ST_INS_RD;
                  end
               end
               OP_APPEND: begin
                  if (!status.full) begin
                     cmd.wr_en     = 1'b1;
                     cmd.wr_sel    = ADDR_COUNT;
                     cmd.count_inc = 1'b1;
                     cmd.set_ok    = 1'b1;
                  end
               end
               OP_REMOVE: begin
                  if (status.pos_in_list) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = ADDR_POS_M1;
                     state_in   = ST_RM_DATA;
                  end
               end
               OP_READ: begin
                  if (status.pos_in_list) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = ADDR_POS_M1;
                     state_in   = ST_RD_DATA;
                  end
               end
               OP_FIND: begin
                  cmd.idx_op = IDX_CLEAR;
                  state_in   = ST_FIND_RD;
               end
               OP_SIZE: begin
                  cmd.set_ok = 1'b1;
               end
               default: begin
                  // unused codes: no effect, ok stays low
               end
            endcase
         end

         ST_INS_RD: begin
            if (status.idx_at_or_above_pos) begin
               // fetch the entry in front of the write slot
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADDR_IDX_M1;
               state_in   = ST_INS_WR;
            end else begin
               // gap is open: drop the new value in
               cmd.wr_en     = 1'b1;
               cmd.wr_sel    = ADDR_POS_M1;
               cmd.count_inc = 1'b1;
               cmd.set_ok    = 1'b1;
               state_in      = ST_DONE;
            end
         end

         ST_INS_WR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = ADDR_IDX;
            cmd.wr_from_ram = 1'b1;
            cmd.idx_op      = IDX_DEC;
            state_in        = ST_INS_RD;
         end

         ST_RM_DATA: begin
            cmd.take_data = 1'b1;
            cmd.idx_op    = IDX_LOAD_POS;
            state_in      = ST_RM_RD;
         end

         ST_RM_RD: begin
            if (status.idx_below_count) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADDR_IDX;
               state_in   = ST_RM_WR;
            end else begin
               cmd.count_dec = 1'b1;
               cmd.set_ok    = 1'b1;
               state_in      = ST_DONE;
            end
         end

         ST_RM_WR: begin
            // move the entry one place forward
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = ADDR_IDX_M1;
            cmd.wr_from_ram = 1'b1;
            cmd.idx_op      = IDX_INC;
            state_in        = ST_RM_RD;
         end

         ST_RD_DATA: begin
            cmd.take_data = 1'b1;
            cmd.set_ok    = 1'b1;
            state_in      = ST_DONE;
         end

         ST_FIND_RD: begin
            if (status.idx_below_count) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADDR_IDX;
               state_in   = ST_FIND_CMP;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_FIND_CMP: begin
            if (status.match) begin
               cmd.take_found = 1'b1;
               cmd.set_ok     = 1'b1;
               state_in       = ST_DONE;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = ST_FIND_RD;
            end
         end

         ST_DONE: begin
            // hold until the response register is free
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/ple_dpath.sv
// ============================================================================
// ple_dpath
// Datapath of the positional list engine: request registers, entry count,
// walk index, list store and response register.
// ============================================================================
module ple_dpath import ple_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   ple_req_if.sink        req_ch,
   ple_rsp_if.source      rsp_ch,
   input  ple_cmd_type    cmd,
   output ple_status_type status
);

   // Request registers
   op_type                  op_ff;
   logic [POS_WIDTH-1:0]    pos_ff;
   logic [VALUE_WIDTH-1:0]  val_ff;

   // List state and walk index
   logic [CNT_WIDTH-1:0]    count_ff;
   logic [CNT_WIDTH-1:0]    idx_ff;
   logic [CNT_WIDTH-1:0]    idx_in;

   // Result under construction
   logic                    res_ok_ff;
   logic [DATA_WIDTH-1:0]   res_data_ff;
   logic [POS_WIDTH-1:0]    res_found_ff;

   // Response register
   logic                    rsp_valid_ff;
   logic                    rsp_ok_ff;
   logic [DATA_WIDTH-1:0]   rsp_data_ff;
   logic [POS_WIDTH-1:0]    rsp_found_ff;
   logic [POS_WIDTH-1:0]    rsp_total_ff;
   logic                    rsp_empty_ff;

   // RAM signals
   logic [ADDR_WIDTH-1:0]   rd_addr;
   logic [ADDR_WIDTH-1:0]   wr_addr;
   logic [VALUE_WIDTH-1:0]  wr_data;
   logic [VALUE_WIDTH-1:0]  rd_data;

   // Wide copies for comparisons
   logic [CMP_WIDTH-1:0]    pos_cmp;
   logic [CMP_WIDTH-1:0]    cnt_cmp;
   logic [CMP_WIDTH-1:0]    idx_cmp;

   assign req_ch.ready = cmd.req_ready;

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= op_type'(req_ch.operation);
         pos_ff <= req_ch.position;
         val_ff <= VALUE_WIDTH'(req_ch.value);
      end
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.count_dec) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   // Walk index
   always_comb begin
      case (cmd.idx_op)
         IDX_LOAD_COUNT: idx_in = count_ff;
         IDX_LOAD_POS:   idx_in = CNT_WIDTH'(pos_ff);
         IDX_CLEAR:      idx_in = '0;
         IDX_INC:        idx_in = idx_ff + 1'b1;
         IDX_DEC:        idx_in = idx_ff - 1'b1;
         default:        idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // RAM address and data selection
   function automatic logic [ADDR_WIDTH-1:0] pick_addr(
      input addr_sel_type         sel,
      input logic [CNT_WIDTH-1:0] idx,
      input logic [POS_WIDTH-1:0] pos,
      input logic [CNT_WIDTH-1:0] cnt
   );
      logic [ADDR_WIDTH-1:0] addr;
      case (sel)
         ADDR_IDX:    addr = ADDR_WIDTH'(idx);
         ADDR_IDX_M1: addr = ADDR_WIDTH'(idx - 1'b1);
         ADDR_POS_M1: addr = ADDR_WIDTH'(pos - 1'b1);
         ADDR_COUNT:  addr = ADDR_WIDTH'(cnt);
         default:     addr = ADDR_WIDTH'(idx);
      endcase
      return addr;
   endfunction

   assign rd_addr = pick_addr(cmd.rd_sel, idx_ff, pos_ff, count_ff);
   assign wr_addr = pick_addr(cmd.wr_sel, idx_ff, pos_ff, count_ff);
   assign wr_data = cmd.wr_from_ram ? rd_data : val_ff;

   ple_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_list_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Build the result; fields default to zero for each new request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         res_ok_ff    <= 1'b0;
         res_data_ff  <= '0;
         res_found_ff <= '0;
      end else begin
         if (cmd.set_ok) begin
            res_ok_ff <= 1'b1;
         end
         if (cmd.take_data) begin
            res_data_ff <= DATA_WIDTH'($unsigned(rd_data));
         end
         if (cmd.take_found) begin
            res_found_ff <= POS_WIDTH'(idx_ff + 1'b1);
         end
      end
   end

   // Response valid: set on load, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_data_ff  <= res_data_ff;
         rsp_found_ff <= res_found_ff;
         rsp_total_ff <= POS_WIDTH'(count_ff);
         rsp_empty_ff <= (count_ff == '0);
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.ok             = rsp_ok_ff;
   assign rsp_ch.data           = rsp_data_ff;
   assign rsp_ch.found_position = rsp_found_ff;
   assign rsp_ch.entry_total    = rsp_total_ff;
   assign rsp_ch.is_empty       = rsp_empty_ff;

   // Status toward the controller
   assign pos_cmp = CMP_WIDTH'(pos_ff);
   assign cnt_cmp = CMP_WIDTH'(count_ff);
   assign idx_cmp = CMP_WIDTH'(idx_ff);

   always_comb begin
      status                     = '0;
      status.req_valid           = req_ch.valid;
      status.op                  = op_ff;
      status.pos_in_list         = (pos_ff != '0) && (pos_cmp <= cnt_cmp);
      status.pos_insertable      = (pos_ff != '0) && (pos_cmp <= cnt_cmp + 1'b1);
      status.full                = (count_ff == CNT_WIDTH'(DEPTH));
      status.idx_at_or_above_pos = (idx_cmp >= pos_cmp);
      status.idx_below_count     = (idx_cmp < cnt_cmp);
      status.match               = (rd_data == val_ff);
      status.rsp_free            = !rsp_valid_ff || rsp_ch.ready;
      status.count               = count_ff;
   end

endmodule
